FILE: rtl/mwms_pkg.sv
package mwms_pkg;

    // Default grid limits handed to the top level.
    parameter int MAX_ROWS_DEF = 64;
    parameter int MAX_COLS_DEF = 64;

    // Fixed field widths.
    parameter int PIX_W     = 13;
    parameter int RES_W     = 13;
    parameter int CFG_W     = 7;
    parameter int CFG_IDX_W = 2;

    // Largest value a configuration register can hold.
    parameter int CFG_MAX = (1 << CFG_W) - 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS = 2'd0,
        REG_GRID_COLS = 2'd1,
        REG_WIN_H     = 2'd2,
        REG_WIN_W     = 2'd3
    } t_cfg_reg;

    // Grid and window sizes after clamping, as seen by the search engine.
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
        logic [CFG_W-1:0] win_h;
        logic [CFG_W-1:0] win_w;
    } t_geom;

    // A size of zero counts as one; anything above the limit saturates.
    function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: rtl/mwms_engine.sv
module mwms_engine #(
    parameter int MAX_ROWS = mwms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mwms_pkg::MAX_COLS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_pix_we,
    input  logic [((MAX_ROWS*MAX_COLS > 1) ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] i_pix_addr,
    input  logic [mwms_pkg::PIX_W-1:0]             i_pix_data,
    input  logic                                   i_start,
    input  mwms_pkg::t_geom                        i_geom,
    input  logic [$clog2(MAX_ROWS*MAX_COLS+1)-1:0] i_total,
    output logic                                   o_busy,
    output logic                                   o_done,
    output logic [mwms_pkg::RES_W-1:0]             o_result
);
    import mwms_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int SW    = $clog2(DEPTH + 2);
    localparam int PW    = $clog2(DEPTH + 1) + 1;
    localparam int CW    = (SW > PIX_W) ? SW : PIX_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_PREP,
        S_MID,
        S_BRD,
        S_BWR,
        S_T0,
        S_T1,
        S_T2
    } t_state;

    t_state r_state;

    // Geometry latched at start.
    logic [CFG_W-1:0] r_cols, r_wh, r_ww, r_rlast, r_clast;
    logic             r_fits;
    logic [TW-1:0]    r_total;

    // Address offsets of the four window corners relative to the top-left cell.
    logic [AW-1:0] r_offh, r_ka, r_kb, r_kc, r_kd;

    // Search bounds and candidate.
    logic [SW-1:0] r_low, r_high, r_mid;

    // Prefix build counters.
    logic [AW-1:0]          r_idx;
    logic [CFG_W-1:0]       r_col;
    logic                   r_row0;
    logic signed [PW-1:0]   r_rowsum;

    // Window scan counters.
    logic [AW-1:0]          r_br;
    logic [CFG_W-1:0]       r_r, r_c;
    logic signed [PW:0]     r_acc;

    // Memories and their registered read data.
    logic [PIX_W-1:0]       r_pix_mem [DEPTH];
    logic signed [PW-1:0]   r_prefix_mem [DEPTH];
    logic [PIX_W-1:0]       r_pix_q;
    logic signed [PW-1:0]   r_qa, r_qb;

    logic [AW-1:0]          w_ra, w_rb;
    logic                   w_pf_we;
    logic signed [PW-1:0]   w_pf_wdata;

    logic [2*CFG_W-1:0]     w_offh_prod;
    logic [SW:0]            w_sum_lh;
    logic [SW-1:0]          w_span;
    logic [TW-1:0]          w_tot_m1;
    logic                   w_build_last;
    logic                   w_win_last;

    logic signed [PW-1:0]   w_v, w_rs, w_up;
    logic signed [PW-1:0]   w_qb_m, w_qc_m, w_qd_m;
    logic signed [PW:0]     w_acc_n;
    logic signed [PW+1:0]   w_sum;
    logic                   w_pos;

    // Shared arithmetic for the sequencer.
    assign w_offh_prod  = (2*CFG_W)'(r_wh - CFG_W'(1)) * (2*CFG_W)'(r_cols);
    assign w_sum_lh     = (SW+1)'(r_low) + (SW+1)'(r_high);
    assign w_span       = r_high - r_low;
    assign w_tot_m1     = r_total - TW'(1);
    assign w_build_last = (TW'(r_idx) == w_tot_m1);
    assign w_win_last   = (r_r == r_rlast) && (r_c == r_clast);

    // One prefix cell: running row sum plus the cell directly above.
    assign w_v        = (CW'(r_pix_q) >= CW'(r_mid)) ? PW'(1) : -PW'(1);
    assign w_rs       = ((r_col == '0) ? '0 : r_rowsum) + w_v;
    assign w_up       = r_row0 ? '0 : r_qa;
    assign w_pf_wdata = w_up + w_rs;
    assign w_pf_we    = (r_state == S_BWR);

    // Window sum from four corners; corners on the border read as zero.
    assign w_qb_m  = (r_r == '0) ? '0 : r_qb;
    assign w_qc_m  = (r_c == '0) ? '0 : r_qa;
    assign w_qd_m  = ((r_r == '0) || (r_c == '0)) ? '0 : r_qb;
    assign w_acc_n = (PW+1)'(r_qa) - (PW+1)'(w_qb_m);
    assign w_sum   = (PW+2)'(r_acc) - (PW+2)'(w_qc_m) + (PW+2)'(w_qd_m);
    assign w_pos   = !w_sum[PW+1] && (w_sum != '0);

    // Read addresses of the prefix memory.
    always_comb begin
        case (r_state)
            S_T0: begin
                w_ra = r_br + r_ka;
                w_rb = r_br + r_kb;
            end
            S_T1: begin
                w_ra = r_br + r_kc;
                w_rb = r_br + r_kd;
            end
            default: begin
                w_ra = r_idx - AW'(r_cols);
                w_rb = r_idx - AW'(r_cols);
            end
        endcase
    end

    // Pixel memory: written during load, read during prefix build.
    always_ff @(posedge i_clk) begin
        if (i_pix_we) begin
            r_pix_mem[i_pix_addr] <= i_pix_data;
        end
        r_pix_q <= r_pix_mem[r_idx];
    end

    // Prefix memory: one write port, two read ports.
    always_ff @(posedge i_clk) begin
        if (w_pf_we) begin
            r_prefix_mem[r_idx] <= w_pf_wdata;
        end
        r_qa <= r_prefix_mem[w_ra];
        r_qb <= r_prefix_mem[w_rb];
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_low   <= SW'(1);
            r_high  <= SW'(1);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cols  <= i_geom.cols;
                        r_wh    <= i_geom.win_h;
                        r_ww    <= i_geom.win_w;
                        r_total <= i_total;
                        r_fits  <= (i_geom.win_h <= i_geom.rows) &&
                                   (i_geom.win_w <= i_geom.cols);
                        r_rlast <= i_geom.rows - i_geom.win_h;
                        r_clast <= i_geom.cols - i_geom.win_w;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_offh  <= AW'(w_offh_prod);
                    r_low   <= SW'(1);
                    // Without a fitting window the search collapses to one.
                    r_high  <= r_fits ? (SW'(r_total) + SW'(1)) : SW'(2);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_ka    <= r_offh + AW'(r_ww) - AW'(1);
                    r_kb    <= AW'(r_ww) - AW'(1) - AW'(r_cols);
                    r_kc    <= r_offh - AW'(1);
                    r_kd    <= AW'(0) - AW'(r_cols) - AW'(1);
                    r_state <= S_MID;
                end
                S_MID: begin
                    if (w_span > SW'(1)) begin
                        r_mid   <= w_sum_lh[SW:1];
                        r_idx   <= '0;
                        r_col   <= '0;
                        r_row0  <= 1'b1;
                        r_state <= S_BRD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_BRD: begin
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    r_rowsum <= w_rs;
                    if (w_build_last) begin
                        r_br    <= '0;
                        r_r     <= '0;
                        r_c     <= '0;
                        r_state <= S_T0;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                        if (r_col == r_cols - CFG_W'(1)) begin
                            r_col  <= '0;
                            r_row0 <= 1'b0;
                        end else begin
                            r_col <= r_col + CFG_W'(1);
                        end
                        r_state <= S_BRD;
                    end
                end
                S_T0: begin
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_acc   <= w_acc_n;
                    r_state <= S_T2;
                end
                S_T2: begin
                    if (w_pos) begin
                        r_low   <= r_mid;
                        r_state <= S_MID;
                    end else if (w_win_last) begin
                        r_high  <= r_mid;
                        r_state <= S_MID;
                    end else begin
                        if (r_c == r_clast) begin
                            r_c  <= '0;
                            r_r  <= r_r + CFG_W'(1);
                            r_br <= r_br + AW'(r_ww);
                        end else begin
                            r_c  <= r_c + CFG_W'(1);
                            r_br <= r_br + AW'(1);
                        end
                        r_state <= S_T0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_MID) && !(w_span > SW'(1));
    assign o_result = RES_W'(r_low);

    // The search interval never becomes empty.
    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID || r_state == S_BRD || r_state == S_T0) |-> (r_low < r_high))
        else $error("search bounds crossed");

    // Each candidate lies strictly inside the search interval.
    a_mid_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BRD) |-> ((r_mid > r_low) && (r_mid < r_high)))
        else $error("candidate outside search interval");

    // The prefix build never runs past the loaded grid.
    a_build_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BWR) |-> (TW'(r_idx) < r_total))
        else $error("prefix build beyond grid");

    // The window scan stays within the placements that fit.
    a_win_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_T0) |-> (r_fits && (r_r <= r_rlast) && (r_c <= r_clast)))
        else $error("window placement out of range");

    // A new grid is only handed over while the engine is idle.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("start while search in progress");

endmodule

FILE: rtl/max_window_median_search.sv
// Maximum window median search. Pixels of a rows x cols grid arrive in row-major
// order, one request per cycle, and are written to an on-chip pixel memory. The
// request that completes the grid starts a binary search of a threshold over
// 1..rows*cols; the answer is the largest threshold for which some window of the
// configured size holds more pixels at or above it than below it, or one if no
// window fits. Each search pass makes two sweeps: a prefix build that reads each
// pixel and then writes its prefix cell (one pixel-memory read port), then a window
// scan over the placements (two prefix-memory read ports, four corners), stopping at
// the first passing window. With N = rows*cols the search makes at most ceil(log2(N))
// passes. Input is not taken while a search runs or while a result waits on the
// output. Sizes of zero count as one, grid sizes saturate at the maximum, and
// configuration must only be written while the block is idle.
module max_window_median_search #(
    parameter int MAX_ROWS = mwms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mwms_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [mwms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mwms_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [mwms_pkg::PIX_W-1:0]     i_pixel_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [mwms_pkg::RES_W-1:0]     o_best_median
);
    import mwms_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam logic [CFG_W-1:0] ROW_HI = (MAX_ROWS > CFG_MAX) ? CFG_W'(CFG_MAX)
                                                                : CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COL_HI = (MAX_COLS > CFG_MAX) ? CFG_W'(CFG_MAX)
                                                                : CFG_W'(MAX_COLS);

    logic [CFG_W-1:0]   r_grid_rows, r_grid_cols, r_win_h, r_win_w;
    logic [AW-1:0]      r_load_cnt;
    logic               r_out_valid;
    logic [RES_W-1:0]   r_best;

    t_geom              w_geom;
    logic [2*CFG_W-1:0] w_prod;
    logic [TW-1:0]      w_total;
    logic               w_in_acc;
    logic               w_last;
    logic               w_busy;
    logic               w_done;
    logic [RES_W-1:0]   w_result;

    // Clamped sizes and grid size.
    assign w_geom.rows  = clamp_size(r_grid_rows, ROW_HI);
    assign w_geom.cols  = clamp_size(r_grid_cols, COL_HI);
    assign w_geom.win_h = clamp_size(r_win_h, CFG_W'(CFG_MAX));
    assign w_geom.win_w = clamp_size(r_win_w, CFG_W'(CFG_MAX));
    assign w_prod       = (2*CFG_W)'(w_geom.rows) * (2*CFG_W)'(w_geom.cols);
    assign w_total      = TW'(w_prod);

    assign o_in_ready = !w_busy && !r_out_valid;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_last     = (TW'(r_load_cnt) + TW'(1)) >= w_total;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= CFG_W'(64);
            r_grid_cols <= CFG_W'(64);
            r_win_h     <= CFG_W'(1);
            r_win_w     <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_GRID_ROWS: r_grid_rows <= i_cfg_wdata;
                REG_GRID_COLS: r_grid_cols <= i_cfg_wdata;
                REG_WIN_H:     r_win_h     <= i_cfg_wdata;
                REG_WIN_W:     r_win_w     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Load counter: wraps to zero on the request that completes the grid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
        end else if (w_in_acc) begin
            if (w_last) begin
                r_load_cnt <= '0;
            end else begin
                r_load_cnt <= r_load_cnt + AW'(1);
            end
        end
    end

    // Output register: holds the result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
            r_best      <= w_result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_best_median = r_best;

    mwms_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pix_we   (w_in_acc),
        .i_pix_addr (r_load_cnt),
        .i_pix_data (i_pixel_value),
        .i_start    (w_in_acc && w_last),
        .i_geom     (w_geom),
        .i_total    (w_total),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_result   (w_result)
    );

endmodule
